>>> hw/rtl/lscr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscr_pkg
// Shared constants and types of the led shift chain refresher.
// ----------------------------------------------------------------------------
package lscr_pkg;

    // frame geometry
    localparam int FRAME_BYTES_DEF = 12;
    localparam int IDX_W           = 4;

    // input item fields
    localparam int ID_W  = 7;
    localparam int NOW_W = 32;

    // configuration
    localparam int                 INTERVAL_W     = 16;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd250;
    localparam int                 APB_ADDR_W     = 3;
    localparam int                 APB_DATA_W     = 32;
    localparam logic               REG_REFRESH_INTERVAL = 1'b0;

    // item kinds carried in tuser
    localparam logic OP_LED_CMD = 1'b0;
    localparam logic OP_POLL    = 1'b1;

    // stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    // frame queue status seen by the back end
    typedef struct packed {
        logic not_empty;
        logic full;
    } t_queue_status;

endpackage

>>> hw/rtl/lscr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscr_front
// Accepts commands and polls, keeps the pending and sent images and the time
// of the last send, and pushes a frame snapshot when a poll calls for a send.
// ----------------------------------------------------------------------------
module lscr_front #(
    parameter int FRAME_BYTES = lscr_pkg::FRAME_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [lscr_pkg::INTERVAL_W-1:0] i_interval,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_op,
    input  logic [lscr_pkg::ID_W-1:0]       i_led_id,
    input  logic                            i_led_on,
    input  logic [lscr_pkg::NOW_W-1:0]      i_now_ms,
    input  logic                            i_q_full,
    output logic                            o_push,
    output logic [FRAME_BYTES*8-1:0]        o_frame
);

    localparam int IMG_W = FRAME_BYTES * 8;
    localparam int BIT_W = $clog2(IMG_W);

    logic [IMG_W-1:0]               r_pending, n_pending;
    logic [IMG_W-1:0]               r_sent;
    logic [lscr_pkg::NOW_W-1:0]     r_last_ms;
    logic                           accept;
    logic                           id_ok;
    logic [3:0]                     slot;
    logic [6:0]                     pos;
    logic [lscr_pkg::NOW_W-1:0]     elapsed;
    logic                           send;

    // accept whenever the queue has room for a frame
    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // bit position of the led in the image
    assign id_ok = {1'b0, i_led_id} < 8'(IMG_W);
    assign slot  = 4'(FRAME_BYTES - 1) - i_led_id[6:3];
    assign pos   = {slot, i_led_id[2:0]};

    always_comb begin
        n_pending = r_pending;
        if (accept && i_op == lscr_pkg::OP_LED_CMD && id_ok) begin
            n_pending[pos[BIT_W-1:0]] = i_led_on;
        end
    end

    // send decision: image changed or refresh interval elapsed
    assign elapsed = i_now_ms - r_last_ms;
    assign send    = accept && i_op == lscr_pkg::OP_POLL &&
                     ((r_pending != r_sent) ||
                      (elapsed >= {{(lscr_pkg::NOW_W-lscr_pkg::INTERVAL_W){1'b0}}, i_interval}));

    assign o_push  = send;
    assign o_frame = r_pending;

    // image and timestamp state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_sent    <= '0;
            r_last_ms <= '0;
        end else begin
            r_pending <= n_pending;
            if (send) begin
                r_sent    <= r_pending;
                r_last_ms <= i_now_ms;
            end
        end
    end

endmodule

>>> hw/rtl/lscr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscr_queue
// Two-entry frame queue between the front end and the byte serialiser.
// ----------------------------------------------------------------------------
module lscr_queue #(
    parameter int WIDTH = lscr_pkg::FRAME_BYTES_DEF * 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [WIDTH-1:0]        i_data,
    input  logic                    i_pop,
    output logic [WIDTH-1:0]        o_head,
    output lscr_pkg::t_queue_status o_status
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_count;

    assign o_head           = r_mem[r_rd];
    assign o_status.not_empty = r_count != 2'd0;
    assign o_status.full      = r_count == 2'd2;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // no push into a full queue unless a pop frees an entry in the same cycle, no pop from an empty one
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_count == 2'd2 && !i_pop))
        else $error("frame queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_count == 2'd0))
        else $error("frame queue underflow");

endmodule

>>> hw/rtl/lscr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscr_back
// Serialises the frame at the queue head into bytes, first byte first,
// flagging the last byte for the latch pulse.
// ----------------------------------------------------------------------------
module lscr_back #(
    parameter int FRAME_BYTES = lscr_pkg::FRAME_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [FRAME_BYTES*8-1:0]   i_head,
    input  lscr_pkg::t_queue_status    i_status,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_byte,
    output logic [lscr_pkg::IDX_W-1:0] o_idx,
    output logic                       o_latch
);

    localparam logic [lscr_pkg::IDX_W-1:0] LAST_IDX = lscr_pkg::IDX_W'(FRAME_BYTES - 1);

    logic [lscr_pkg::IDX_W-1:0] r_idx;
    logic                       fire;
    logic                       last;

    assign o_valid = i_status.not_empty;
    assign fire    = o_valid && i_ready;
    assign last    = r_idx == LAST_IDX;
    assign o_pop   = fire && last;
    assign o_idx   = r_idx;
    assign o_latch = last;

    // byte select
    always_comb begin
        o_byte = '0;
        for (int k = 0; k < FRAME_BYTES; k++) begin
            if (r_idx == lscr_pkg::IDX_W'(k)) begin
                o_byte = i_head[k*8 +: 8];
            end
        end
    end

    // byte counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (fire) begin
            r_idx <= last ? '0 : r_idx + lscr_pkg::IDX_W'(1);
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_IDX)
        else $error("byte index past end of frame");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && last) |=> (r_idx == '0))
        else $error("frame did not restart at byte zero");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_idx == '0 && !o_valid))
        else $error("serialiser active after reset");

endmodule

>>> hw/rtl/led_shift_chain_refresher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_shift_chain_refresher
// LED image refresher for a shift register chain: led commands and timed
// polls in, frame bytes with a latch flag out.
// ----------------------------------------------------------------------------
// Throughput: one input transaction per cycle while the two-entry frame queue
//   has room; each sent frame holds the output for FRAME_BYTES transactions.
// Latency: with the queue empty, the first byte of a frame is valid the cycle
//   after the poll is taken; a frame already queued delays it by its bytes.
// Reset (synchronous, active low): images and last send time cleared, queue
//   emptied, refresh interval back to 250 ms.
module led_shift_chain_refresher #(
    parameter int FRAME_BYTES = lscr_pkg::FRAME_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // led_id[6:0], led_on[7], now_ms[39:8]
    input  logic [lscr_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tuser,   // op[0]
    // output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // frame_byte[7:0], byte_index[11:8], zero[15:12]
    output logic [lscr_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast,   // latch
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lscr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lscr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lscr_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int IMG_W = FRAME_BYTES * 8;

    logic [lscr_pkg::INTERVAL_W-1:0] r_interval;
    logic                            cfg_wr;
    logic                            push;
    logic                            pop;
    logic [IMG_W-1:0]                frame;
    logic [IMG_W-1:0]                head;
    lscr_pkg::t_queue_status         q_status;
    logic [7:0]                      out_byte;
    logic [lscr_pkg::IDX_W-1:0]      out_idx;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    paddr[2] == lscr_pkg::REG_REFRESH_INTERVAL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= lscr_pkg::INTERVAL_RESET;
        end else if (cfg_wr) begin
            r_interval <= pwdata[lscr_pkg::INTERVAL_W-1:0];
        end
    end

    assign prdata = (paddr[2] == lscr_pkg::REG_REFRESH_INTERVAL) ?
                    {{(lscr_pkg::APB_DATA_W-lscr_pkg::INTERVAL_W){1'b0}}, r_interval} : '0;

    // front end
    lscr_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_interval (r_interval),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_op       (s_axis_tuser),
        .i_led_id   (s_axis_tdata[6:0]),
        .i_led_on   (s_axis_tdata[7]),
        .i_now_ms   (s_axis_tdata[39:8]),
        .i_q_full   (q_status.full),
        .o_push     (push),
        .o_frame    (frame)
    );

    // frame queue
    lscr_queue #(
        .WIDTH(IMG_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (frame),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // byte serialiser
    lscr_back #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_status (q_status),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_byte   (out_byte),
        .o_idx    (out_idx),
        .o_latch  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, out_idx, out_byte};

endmodule

>>> bench/tb_led_shift_chain_refresher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_shift_chain_refresher
// Self-checking bench for the led shift chain refresher. LED commands and
// timed polls go in on the input stream, and a local image model predicts
// each frame byte. Every output transaction is checked against the oldest
// prediction. The refresh interval is rewritten over APB between phases,
// only once the block has gone idle.
// ----------------------------------------------------------------------------
module tb_led_shift_chain_refresher;

    localparam int N_BYTES        = lscr_pkg::FRAME_BYTES_DEF;
    localparam int LED_COUNT      = N_BYTES * 8;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic                       op;
        logic [lscr_pkg::ID_W-1:0]  led_id;
        logic                       led_on;
        logic [lscr_pkg::NOW_W-1:0] now_ms;
    } t_led_item;

    typedef struct packed {
        logic [7:0]                 frame_byte;
        logic [lscr_pkg::IDX_W-1:0] byte_index;
        logic                       latch;
    } t_frame_byte;

    // dut ports
    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // led_id[6:0], led_on[7], now_ms[39:8]
    logic [lscr_pkg::S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                            s_axis_tuser  = 1'b0; // op[0]
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // frame_byte[7:0], byte_index[11:8], zero[15:12]
    logic [lscr_pkg::M_TDATA_W-1:0]  m_axis_tdata;
    logic                            m_axis_tlast;         // latch
    logic                            psel          = 1'b0;
    logic                            penable       = 1'b0;
    logic                            pwrite        = 1'b0;
    logic [lscr_pkg::APB_ADDR_W-1:0] paddr         = '0;
    logic [lscr_pkg::APB_DATA_W-1:0] pwdata        = '0;
    logic [lscr_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // stimulus and predicted frame bytes
    t_led_item   led_item_q[$];
    t_frame_byte frame_byte_q[$];
    t_led_item   next_item;
    t_frame_byte got_byte;
    t_frame_byte want_byte;

    // image model
    logic [7:0]                      pending_img [N_BYTES] = '{default: 8'h00};
    logic [7:0]                      sent_img    [N_BYTES] = '{default: 8'h00};
    logic [lscr_pkg::NOW_W-1:0]      last_send_ms = '0;
    logic [lscr_pkg::INTERVAL_W-1:0] interval_ms  = lscr_pkg::INTERVAL_RESET;

    logic [lscr_pkg::NOW_W-1:0] gen_ms       = '0;
    logic                       quiet        = 1'b0;
    int                         src_gap      = 0;
    int                         sink_gap     = 0;
    int                         mismatches   = 0;
    int                         stall_cycles = 0;

    led_shift_chain_refresher dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // image update and frame prediction for one accepted item
    task automatic predict_refresh(input t_led_item it);
        int          slot;
        int          i;
        logic        changed;
        t_frame_byte fb;
        if (it.op == lscr_pkg::OP_LED_CMD) begin
            // ids past the chain change nothing
            if (int'(it.led_id) < LED_COUNT) begin
                slot = N_BYTES - 1 - int'(it.led_id[6:3]);
                pending_img[slot][it.led_id[2:0]] = it.led_on;
            end
        end else begin
            changed = 1'b0;
            for (i = 0; i < N_BYTES; i++) begin
                if (pending_img[i] != sent_img[i]) changed = 1'b1;
            end
            // elapsed time wraps modulo 2^32
            if (changed ||
                (it.now_ms - last_send_ms) >= lscr_pkg::NOW_W'(interval_ms)) begin
                sent_img     = pending_img;
                last_send_ms = it.now_ms;
                for (i = 0; i < N_BYTES; i++) begin
                    fb.frame_byte = sent_img[i];
                    fb.byte_index = lscr_pkg::IDX_W'(i);
                    fb.latch      = (i == N_BYTES - 1);
                    frame_byte_q.push_back(fb);
                end
            end
        end
    endtask

    // ignored fields carry random junk
    task automatic push_cmd(input int id, input logic on);
        t_led_item it;
        it.op     = lscr_pkg::OP_LED_CMD;
        it.led_id = lscr_pkg::ID_W'(id);
        it.led_on = on;
        it.now_ms = $urandom;
        led_item_q.push_back(it);
    endtask

    task automatic push_poll(input logic [lscr_pkg::NOW_W-1:0] t);
        t_led_item it;
        it.op     = lscr_pkg::OP_POLL;
        it.led_id = lscr_pkg::ID_W'($urandom);
        it.led_on = 1'($urandom);
        it.now_ms = t;
        led_item_q.push_back(it);
    endtask

    // random mix of commands and polls, poll times walking around the interval
    task automatic fill_random(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) < 6) begin
                if ($urandom_range(0, 7) == 0)
                    push_cmd($urandom_range(LED_COUNT, 127), 1'($urandom));
                else
                    push_cmd($urandom_range(0, LED_COUNT - 1), 1'($urandom));
            end else begin
                case ($urandom_range(0, 3))
                    0: gen_ms = gen_ms + $urandom_range(0, interval_ms);
                    1: gen_ms = gen_ms + interval_ms + $urandom_range(0, 2) - 1;
                    2: gen_ms = gen_ms + $urandom;
                    default: ;
                endcase
                push_poll(gen_ms);
            end
        end
    endtask

    // hold off until every item is taken and every frame byte is back
    task automatic wait_idle();
        while (led_item_q.size() != 0 || s_axis_tvalid || frame_byte_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // apb write of the refresh interval: setup then access
    task automatic set_interval(input logic [lscr_pkg::INTERVAL_W-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lscr_pkg::APB_ADDR_W'(4 * int'(lscr_pkg::REG_REFRESH_INTERVAL));
        pwdata  <= lscr_pkg::APB_DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        interval_ms = v;
        @(negedge i_clk);
    endtask

    // input stream driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap       <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (src_gap != 0 && !quiet) begin
                s_axis_tvalid <= 1'b0;
                src_gap       <= src_gap - 1;
            end else if (led_item_q.size() != 0) begin
                next_item = led_item_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {next_item.now_ms, next_item.led_on, next_item.led_id};
                s_axis_tuser  <= next_item.op;
                if (!quiet && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 17);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output stream back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap      <= 0;
        end else if (sink_gap != 0 && !quiet) begin
            m_axis_tready <= 1'b0;
            sink_gap      <= sink_gap - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            m_axis_tready <= 1'b0;
            sink_gap      <= $urandom_range(0, 16);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor: check frame bytes, then predict from the accepted item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_byte.frame_byte = m_axis_tdata[7:0];
                got_byte.byte_index = m_axis_tdata[11:8];
                got_byte.latch      = m_axis_tlast;
                if (frame_byte_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected byte %h index %0d latch %b", $realtime,
                                 got_byte.frame_byte, got_byte.byte_index, got_byte.latch);
                    mismatches++;
                end else begin
                    want_byte = frame_byte_q.pop_front();
                    if (got_byte.frame_byte !== want_byte.frame_byte ||
                        got_byte.byte_index !== want_byte.byte_index ||
                        got_byte.latch !== want_byte.latch) begin
                        if (mismatches < 10)
                            $display("%0t: byte exp %h/%0d/%b got %h/%0d/%b", $realtime,
                                     want_byte.frame_byte, want_byte.byte_index, want_byte.latch,
                                     got_byte.frame_byte, got_byte.byte_index, got_byte.latch);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_refresh({s_axis_tuser, s_axis_tdata[6:0], s_axis_tdata[7],
                                 s_axis_tdata[39:8]});
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[led_shift_chain_refresher] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset interval, boundaries, ignored ids, no-change polls, time wrap
        push_poll(32'd0);
        push_poll(32'd249);
        push_poll(32'd250);
        push_cmd(0, 1'b1);
        push_cmd(LED_COUNT - 1, 1'b1);
        push_cmd(LED_COUNT, 1'b1);
        push_cmd(127, 1'b1);
        push_poll(32'd251);
        push_poll(32'd252);
        push_cmd(0, 1'b0);
        push_cmd(0, 1'b1);
        push_poll(32'd253);
        push_cmd(8, 1'b1);
        push_cmd(42, 1'b1);
        push_cmd(63, 1'b1);
        push_poll(32'hFFFF_FFFF);
        push_poll(32'h0000_0010);
        push_poll(32'd248);
        push_poll(32'd249);
        push_cmd(LED_COUNT - 1, 1'b0);
        push_cmd(127, 1'b0);
        push_poll(32'd249);
        wait_idle();

        // zero interval: every poll sends
        set_interval('0);
        gen_ms = $urandom;
        fill_random(35);
        wait_idle();

        // longest interval
        set_interval('1);
        fill_random(35);
        wait_idle();

        set_interval(lscr_pkg::INTERVAL_W'($urandom_range(2, 2000)));
        gen_ms = $urandom;
        fill_random(35);
        wait_idle();

        // last phase runs without idling
        quiet = 1'b1;
        set_interval(lscr_pkg::INTERVAL_W'(1));
        fill_random(25);
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && frame_byte_q.size() == 0) begin
            $display("[led_shift_chain_refresher] OK");
        end else begin
            $display("[led_shift_chain_refresher] ERROR");
        end
        $finish;
    end

endmodule
